// File: rtl/plic_pkg.sv
// Shared types and constants for the posting list intersection counter.
package plic_pkg;

  localparam int unsigned ITEM_COUNT_W = 11;
  localparam int unsigned COUNT_W      = 9;
  localparam int unsigned STATUS_W     = 2;

  localparam logic [ITEM_COUNT_W-1:0] ITEM_COUNT_RST = 11'd1024;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [15:0] member;
    logic [9:0]  item_a;
    logic [9:0]  item_b;
  } plic_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  common_count;
    logic [STATUS_W-1:0] status;
  } plic_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEN,
    ST_MERGE,
    ST_DONE
  } plic_state_e;

endpackage

// File: rtl/plic_mem.sv
// List length memory and list entry memory with registered read data.
module plic_mem #(
  parameter int unsigned NUM_ITEMS   = 1024,
  parameter int unsigned LIST_CAP    = 256,
  parameter int unsigned MEMBER_BITS = 16,
  localparam int unsigned IW  = $clog2(NUM_ITEMS),
  localparam int unsigned CIW = $clog2(LIST_CAP),
  localparam int unsigned LW  = $clog2(LIST_CAP + 1)
) (
  input  logic                   clk_i,
  input  logic [IW-1:0]          len_raddr_a_i,
  input  logic [IW-1:0]          len_raddr_b_i,
  output logic [LW-1:0]          len_rdata_a_o,
  output logic [LW-1:0]          len_rdata_b_o,
  input  logic                   len_we_i,
  input  logic [IW-1:0]          len_waddr_i,
  input  logic [LW-1:0]          len_wdata_i,
  input  logic [IW-1:0]          ent_rrow_a_i,
  input  logic [CIW-1:0]         ent_rcol_a_i,
  input  logic [IW-1:0]          ent_rrow_b_i,
  input  logic [CIW-1:0]         ent_rcol_b_i,
  output logic [MEMBER_BITS-1:0] ent_rdata_a_o,
  output logic [MEMBER_BITS-1:0] ent_rdata_b_o,
  input  logic                   ent_we_i,
  input  logic [IW-1:0]          ent_wrow_i,
  input  logic [CIW-1:0]         ent_wcol_i,
  input  logic [MEMBER_BITS-1:0] ent_wdata_i
);

  logic [LW-1:0]          len_mem [NUM_ITEMS];
  logic [MEMBER_BITS-1:0] ent_mem [NUM_ITEMS][LIST_CAP];

  logic [LW-1:0]          len_a_q, len_b_q;
  logic [MEMBER_BITS-1:0] ent_a_q, ent_b_q;

  always_ff @(posedge clk_i) begin
    if (len_we_i) begin
      len_mem[len_waddr_i] <= len_wdata_i;
    end
    len_a_q <= len_mem[len_raddr_a_i];
    len_b_q <= len_mem[len_raddr_b_i];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we_i) begin
      ent_mem[ent_wrow_i][ent_wcol_i] <= ent_wdata_i;
    end
    ent_a_q <= ent_mem[ent_rrow_a_i][ent_rcol_a_i];
    ent_b_q <= ent_mem[ent_rrow_b_i][ent_rcol_b_i];
  end

  assign len_rdata_a_o = len_a_q;
  assign len_rdata_b_o = len_b_q;
  assign ent_rdata_a_o = ent_a_q;
  assign ent_rdata_b_o = ent_b_q;

endmodule

// File: rtl/posting_list_intersection_count.sv
// Top level: per-item lists, appended to by add, with a two-pointer intersection count.
//
//  channel | dir | signals                              | word
//  --------+-----+--------------------------------------+---------------------------------
//  in      | in  | in_valid_i, in_ready_o, in_data_i    | kind, member, item_a, item_b
//  out     | out | out_valid_o, out_ready_i, out_data_o | common_count, status
//  cfg     | in  | cfg_valid_i, cfg_ready_o, cfg_data_i | item_count
//
// An add passes through ST_LEN and ST_DONE before its result is loaded; a rejected word goes straight to ST_DONE.
// A query reads both lengths in ST_LEN, then does one merge step per cycle on the two
// read ports of the entry memory in ST_MERGE until either list is used up.
// After reset the length memory is swept to zero in ST_CLEAR, with in_ready_o low until every entry is cleared.
// A result waits in the output register; the next word is taken meanwhile.
module posting_list_intersection_count #(
  parameter int unsigned NUM_ITEMS   = 1024,
  parameter int unsigned LIST_CAP    = 256,
  parameter int unsigned MEMBER_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  plic_pkg::plic_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output plic_pkg::plic_out_t                 out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [plic_pkg::ITEM_COUNT_W-1:0]   cfg_data_i
);

  localparam int unsigned IW  = $clog2(NUM_ITEMS);
  localparam int unsigned CIW = $clog2(LIST_CAP);
  localparam int unsigned LW  = $clog2(LIST_CAP + 1);

  plic_pkg::plic_state_e state_q, state_d;

  logic [IW-1:0]                     clr_q, clr_d;
  logic                              kind_q, kind_d;
  logic [MEMBER_BITS-1:0]            member_q, member_d;
  logic [IW-1:0]                     row_a_q, row_a_d, row_b_q, row_b_d;
  logic [LW-1:0]                     na_q, na_d, nb_q, nb_d;
  logic [LW-1:0]                     i_q, i_d, j_q, j_d, cnt_q, cnt_d;
  logic [plic_pkg::STATUS_W-1:0]     status_q, status_d;
  logic [plic_pkg::ITEM_COUNT_W-1:0] item_count_q;
  logic                              out_valid_q, out_valid_d;
  plic_pkg::plic_out_t               out_q;
  logic                              out_load;

  logic [IW-1:0]          len_raddr_a, len_raddr_b, len_waddr;
  logic [LW-1:0]          len_rdata_a, len_rdata_b, len_wdata;
  logic                   len_we, ent_we;
  logic [MEMBER_BITS-1:0] ent_rdata_a, ent_rdata_b;
  logic                   a_ok, b_ok;

  assign a_ok = ({1'b0, in_data_i.item_a} < item_count_q) &&
                (32'(in_data_i.item_a) < NUM_ITEMS);
  assign b_ok = ({1'b0, in_data_i.item_b} < item_count_q) &&
                (32'(in_data_i.item_b) < NUM_ITEMS);

  assign len_raddr_a = IW'(in_data_i.item_a);
  assign len_raddr_b = IW'(in_data_i.item_b);

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    kind_d     = kind_q;
    member_d   = member_q;
    row_a_d    = row_a_q;
    row_b_d    = row_b_q;
    na_d       = na_q;
    nb_d       = nb_q;
    i_d        = i_q;
    j_d        = j_q;
    cnt_d      = cnt_q;
    status_d   = status_q;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    len_we     = 1'b0;
    len_waddr  = row_a_q;
    len_wdata  = len_rdata_a + 1'b1;
    ent_we     = 1'b0;
    case (state_q)
      plic_pkg::ST_CLEAR: begin
        len_we    = 1'b1;
        len_waddr = clr_q;
        len_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IW'(NUM_ITEMS - 1)) begin
          state_d = plic_pkg::ST_IDLE;
        end
      end
      plic_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        i_d        = '0;
        j_d        = '0;
        if (in_valid_i) begin
          kind_d   = in_data_i.kind;
          member_d = MEMBER_BITS'(in_data_i.member);
          row_a_d  = IW'(in_data_i.item_a);
          row_b_d  = IW'(in_data_i.item_b);
          cnt_d    = '0;
          if (!a_ok || (in_data_i.kind == plic_pkg::KIND_QUERY && !b_ok)) begin
            status_d = plic_pkg::STATUS_RANGE;
            state_d  = plic_pkg::ST_DONE;
          end else begin
            status_d = plic_pkg::STATUS_OK;
            state_d  = plic_pkg::ST_LEN;
          end
        end
      end
      plic_pkg::ST_LEN: begin
        i_d = '0;
        j_d = '0;
        if (kind_q == plic_pkg::KIND_ADD) begin
          if (len_rdata_a >= LW'(LIST_CAP)) begin
            status_d = plic_pkg::STATUS_FULL;
          end else begin
            len_we = 1'b1;
            ent_we = 1'b1;
          end
          state_d = plic_pkg::ST_DONE;
        end else begin
          na_d = len_rdata_a;
          nb_d = len_rdata_b;
          if (len_rdata_a == '0 || len_rdata_b == '0) begin
            state_d = plic_pkg::ST_DONE;
          end else begin
            state_d = plic_pkg::ST_MERGE;
          end
        end
      end
      plic_pkg::ST_MERGE: begin
        if (ent_rdata_a == ent_rdata_b) begin
          cnt_d = cnt_q + 1'b1;
          i_d   = i_q + 1'b1;
          j_d   = j_q + 1'b1;
        end else if (ent_rdata_a < ent_rdata_b) begin
          i_d = i_q + 1'b1;
        end else begin
          j_d = j_q + 1'b1;
        end
        if (i_d == na_q || j_d == nb_q) begin
          state_d = plic_pkg::ST_DONE;
        end
      end
      plic_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = plic_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = plic_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= plic_pkg::ST_CLEAR;
      clr_q        <= '0;
      kind_q       <= plic_pkg::KIND_ADD;
      row_a_q      <= '0;
      row_b_q      <= '0;
      na_q         <= '0;
      nb_q         <= '0;
      i_q          <= '0;
      j_q          <= '0;
      cnt_q        <= '0;
      status_q     <= plic_pkg::STATUS_OK;
      out_valid_q  <= 1'b0;
      item_count_q <= plic_pkg::ITEM_COUNT_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      kind_q      <= kind_d;
      row_a_q     <= row_a_d;
      row_b_q     <= row_b_d;
      na_q        <= na_d;
      nb_q        <= nb_d;
      i_q         <= i_d;
      j_q         <= j_d;
      cnt_q       <= cnt_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        item_count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    member_q <= member_d;
    if (out_load) begin
      out_q.common_count <= plic_pkg::COUNT_W'(cnt_q);
      out_q.status       <= status_q;
    end
  end

  plic_mem #(
    .NUM_ITEMS  (NUM_ITEMS),
    .LIST_CAP   (LIST_CAP),
    .MEMBER_BITS(MEMBER_BITS)
  ) u_mem (
    .clk_i        (clk_i),
    .len_raddr_a_i(len_raddr_a),
    .len_raddr_b_i(len_raddr_b),
    .len_rdata_a_o(len_rdata_a),
    .len_rdata_b_o(len_rdata_b),
    .len_we_i     (len_we),
    .len_waddr_i  (len_waddr),
    .len_wdata_i  (len_wdata),
    .ent_rrow_a_i (row_a_q),
    .ent_rcol_a_i (i_d[CIW-1:0]),
    .ent_rrow_b_i (row_b_q),
    .ent_rcol_b_i (j_d[CIW-1:0]),
    .ent_rdata_a_o(ent_rdata_a),
    .ent_rdata_b_o(ent_rdata_b),
    .ent_we_i     (ent_we),
    .ent_wrow_i   (row_a_q),
    .ent_wcol_i   (len_rdata_a[CIW-1:0]),
    .ent_wdata_i  (member_q)
  );

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_merge_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == plic_pkg::ST_MERGE |-> (i_q < na_q) && (j_q < nb_q))
    else $error("merge pointer past list length");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == plic_pkg::ST_MERGE |-> (cnt_q <= i_q) && (cnt_q <= j_q))
    else $error("match count exceeds merge pointers");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && status_q != plic_pkg::STATUS_OK |-> cnt_q == '0)
    else $error("rejected word carries a nonzero count");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in work");

endmodule
